// ----- rtl/lmcf_pkg.sv -----
// lmcf_pkg: shared types and constants for the cycle finder
// no dependencies
package lmcf_pkg;

    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF   = 48;
    localparam int MAX_EMITTED_DEF   = 64;
    localparam int VW                = VALUE_WIDTH_DEF;
    localparam int TOL_W             = 47;
    localparam int LIM_W             = 11;
    localparam int IDX_W             = 10;
    localparam int LEN_W             = 11;
    localparam int ADDR_W            = 1;

    localparam logic [ADDR_W-1:0] REG_TOL = 1'd0;
    localparam logic [ADDR_W-1:0] REG_LIM = 1'd1;

    localparam logic [TOL_W-1:0] TOL_RESET = 47'd10995116;
    localparam logic [LIM_W-1:0] LIM_RESET = 11'd1000;

    typedef struct packed {
        logic signed [VW-1:0] growth_rate;
        logic signed [VW-1:0] start_value;
    } in_item_t;

    typedef struct packed {
        logic                 converged;
        logic signed [VW-1:0] cycle_value;
        logic [IDX_W-1:0]     value_index;
        logic [LEN_W-1:0]     cycle_length;
        logic [LEN_W-1:0]     steps_to_cycle;
        logic                 truncated;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_STORE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT,
        ST_NOCONV
    } state_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_P1,
        MUL_P2,
        MUL_DONE
    } mstate_t;

endpackage

// ----- rtl/lmcf_map.sv -----
// lmcf_map: one logistic map step r*x*(1-x), two saturating fixed-point multiplies
// uses lmcf_pkg; each multiply is split into 24x24-bit partial products over cycles
module lmcf_map
    import lmcf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x,
    input  logic [VALUE_WIDTH-1:0] r,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] y
);

    localparam int W  = VALUE_WIDTH;
    localparam int FB = W - 8;
    localparam int HW = (W + 1) / 2;
    localparam logic [W-1:0] VSIGN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VMAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE   = W'(1) << FB;

    mstate_t st_reg, st_next;
    logic        pass_reg, pass_next;
    logic [W-1:0] a_reg, a_next, b_reg, b_next, omx_reg, omx_next;
    logic         neg_reg, neg_next;
    logic [2*HW-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*HW-1:0] ll_next, lh_next, hl_next, hh_next;
    logic [W-1:0] y_reg, y_next;
    logic         done_reg, done_next;

    logic [W-1:0] diff, omx;
    logic [4*HW-1:0] prod;
    logic [4*HW-1:0] q;
    logic [W-1:0] qs;
    logic [W-1:0] res;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    always_comb
    begin
        diff = ONE - x;
        omx  = diff;
        if ((ONE[W-1] != x[W-1]) && (ONE[W-1] != diff[W-1]))
        begin
            omx = VMAXP;
        end
    end

    always_comb
    begin
        prod = {{(2*HW){1'b0}}, ll_reg} + ({{(2*HW){1'b0}}, lh_reg} << HW)
             + ({{(2*HW){1'b0}}, hl_reg} << HW) + ({hh_reg, {(2*HW){1'b0}}});
        q  = prod >> FB;
        qs = q[W-1:0];
        if ((q >> W) != '0 || q[W-1:0] > (neg_reg ? VSIGN : VMAXP))
        begin
            qs = neg_reg ? VSIGN : VMAXP;
        end
        res = neg_reg ? (~qs + W'(1)) : qs;
    end

    always_comb
    begin
        st_next   = st_reg;
        pass_next = pass_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        omx_next  = omx_reg;
        neg_next  = neg_reg;
        ll_next   = ll_reg;
        lh_next   = lh_reg;
        hl_next   = hl_reg;
        hh_next   = hh_reg;
        y_next    = y_reg;
        done_next = 1'b0;
        case (st_reg)
            MUL_IDLE:
            begin
                if (start)
                begin
                    a_next    = mag(r);
                    b_next    = mag(x);
                    neg_next  = r[W-1] ^ x[W-1];
                    omx_next  = omx;
                    pass_next = 1'b0;
                    st_next   = MUL_P1;
                end
            end
            MUL_P1:
            begin
                ll_next = (2*HW)'(a_reg[HW-1:0]) * (2*HW)'(b_reg[HW-1:0]);
                lh_next = (2*HW)'(a_reg[HW-1:0]) * (2*HW)'(b_reg[W-1:HW]);
                st_next = MUL_P2;
            end
            MUL_P2:
            begin
                hl_next = (2*HW)'(a_reg[W-1:HW]) * (2*HW)'(b_reg[HW-1:0]);
                hh_next = (2*HW)'(a_reg[W-1:HW]) * (2*HW)'(b_reg[W-1:HW]);
                st_next = MUL_DONE;
            end
            MUL_DONE:
            begin
                if (!pass_reg)
                begin
                    a_next    = mag(res);
                    b_next    = mag(omx_reg);
                    neg_next  = res[W-1] ^ omx_reg[W-1];
                    pass_next = 1'b1;
                    st_next   = MUL_P1;
                end
                else
                begin
                    y_next    = res;
                    done_next = 1'b1;
                    st_next   = MUL_IDLE;
                end
            end
            default:
            begin
                st_next = MUL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MUL_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        omx_reg  <= omx_next;
        neg_reg  <= neg_next;
        ll_reg   <= ll_next;
        lh_reg   <= lh_next;
        hl_reg   <= hl_next;
        hh_reg   <= hh_next;
        y_reg    <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ----- rtl/lmcf_core.sv -----
// lmcf_core: sequencer with orbit history and cycle store memories, scan and emit
// uses lmcf_pkg and lmcf_map
module lmcf_core
    import lmcf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_EMITTED   = MAX_EMITTED_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic [TOL_W-1:0] tol,
    input  logic [LIM_W-1:0] lim
);

    localparam int W  = VW;
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = AW + 1;

    logic [W-1:0] hist_mem [HISTORY_DEPTH];
    logic [W-1:0] cyc_mem  [HISTORY_DEPTH];
    logic [W-1:0] hist_q, cyc_q;
    logic         h_we, c_we;
    logic [AW-1:0] wa, ra;

    state_t st_reg, st_next;
    logic [W-1:0] r_reg, r_next, x_reg, x_next;
    logic [CW-1:0] n_reg, n_next, j_reg, j_next, limit_reg, limit_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          rec_reg, rec_next, hit_reg, hit_next;
    logic          mstart;
    logic          mdone;
    logic [W-1:0]  my;
    out_item_t     o_reg, o_next;
    logic          ov_reg, ov_next;
    logic [CW-1:0] emit;

    logic [W-1:0] rq, ux, ua, dd;
    logic         close;

    lmcf_map #(.VALUE_WIDTH(VW)) u_map
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .x     (x_reg),
        .r     (r_reg),
        .done  (mdone),
        .y     (my)
    );

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hist_mem[wa] <= x_reg;
        end
        if (c_we)
        begin
            cyc_mem[wa] <= x_reg;
        end
        hist_q <= hist_mem[ra];
        cyc_q  <= cyc_mem[ra];
    end

    always_comb
    begin
        rq    = rec_reg ? cyc_q : hist_q;
        ux    = x_reg ^ {1'b1, {(W-1){1'b0}}};
        ua    = rq ^ {1'b1, {(W-1){1'b0}}};
        dd    = (ux > ua) ? (ux - ua) : (ua - ux);
        close = (W+TOL_W)'(dd) < (W+TOL_W)'(tol);
        emit  = (32'(n_reg) < 32'(MAX_EMITTED)) ? n_reg : CW'(MAX_EMITTED);
    end

    always_comb
    begin
        st_next    = st_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        limit_next = limit_reg;
        steps_next = steps_reg;
        rec_next   = rec_reg;
        hit_next   = hit_reg;
        o_next     = o_reg;
        ov_next    = ov_reg;
        mstart     = 1'b0;
        h_we       = 1'b0;
        c_we       = 1'b0;
        wa         = n_reg[AW-1:0];
        ra         = j_reg[AW-1:0];
        in_ready   = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    r_next     = in_data.growth_rate;
                    x_next     = in_data.start_value;
                    limit_next = ((LIM_W+CW)'(lim) > (LIM_W+CW)'(HISTORY_DEPTH)) ?
                                 CW'(HISTORY_DEPTH) : CW'(lim);
                    n_next     = '0;
                    rec_next   = 1'b0;
                    st_next    = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                mstart  = 1'b1;
                st_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (mdone)
                begin
                    x_next = my;
                    if (n_reg == limit_reg)
                    begin
                        st_next = rec_reg ? ST_EMIT_RD : ST_NOCONV;
                    end
                    else
                    begin
                        st_next = ST_STORE;
                    end
                end
            end
            ST_STORE:
            begin
                h_we   = !rec_reg;
                c_we   = rec_reg;
                n_next = n_reg + CW'(1);
                mstart = 1'b1;
                st_next = ST_SCAN;
                j_next  = '0;
            end
            ST_SCAN:
            begin
                if (mdone)
                begin
                    x_next   = my;
                    hit_next = 1'b0;
                    st_next  = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                if (j_reg != '0 && close)
                begin
                    hit_next = 1'b1;
                end
                if (j_reg == n_reg || (j_reg != '0 && close))
                begin
                    if ((j_reg != '0 && close) || hit_reg)
                    begin
                        if (!rec_reg)
                        begin
                            steps_next = n_reg;
                            rec_next   = 1'b1;
                            n_next     = '0;
                            st_next    = (limit_reg == '0) ? ST_EMIT_RD : ST_STORE;
                        end
                        else
                        begin
                            st_next = ST_EMIT_RD;
                        end
                    end
                    else if (n_reg == limit_reg)
                    begin
                        st_next = rec_reg ? ST_EMIT_RD : ST_NOCONV;
                    end
                    else
                    begin
                        st_next = ST_STORE;
                    end
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    ra     = j_reg[AW-1:0];
                end
            end
            ST_EMIT_RD:
            begin
                j_next  = '0;
                st_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next               = 1'b1;
                    o_next.converged      = 1'b1;
                    o_next.cycle_value    = cyc_q;
                    o_next.value_index    = IDX_W'(j_reg);
                    o_next.cycle_length   = LEN_W'(n_reg);
                    o_next.steps_to_cycle = LEN_W'(steps_reg);
                    o_next.truncated      = 32'(n_reg) > 32'(MAX_EMITTED);
                    o_next.last           = (j_reg + CW'(1) == emit);
                    j_next                = j_reg + CW'(1);
                    ra                    = j_next[AW-1:0];
                    st_next = (j_reg + CW'(1) == emit) ? ST_IDLE : ST_EMIT_WAIT;
                end
                else
                begin
                    ra = j_reg[AW-1:0];
                end
            end
            ST_NOCONV:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    o_next  = '0;
                    o_next.last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        j_reg     <= j_next;
        limit_reg <= limit_next;
        steps_reg <= steps_next;
        rec_reg   <= rec_next;
        hit_reg   <= hit_next;
        o_reg     <= o_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = o_reg;

endmodule

// ----- rtl/logistic_map_cycle_finder.sv -----
// logistic_map_cycle_finder: top level with the register port and the core
// uses lmcf_pkg and lmcf_core
//
// usage: an item on in_* carries growth rate r and start value x (signed Q7.40).
// the block iterates the logistic map, stores each value in the orbit history
// memory and compares each new value with every stored one, one entry a cycle
// through the memory read port. after a match it records the cycle into the
// cycle store the same way, then emits one item per cycle value (at most
// MAX_EMITTED, last marks the final one), or a single non-converged item.
// a map step is two multiplies of four 24x24 partial products each; after
// each step the new value is scanned against the history stored so far.
// the next item is taken only after the last result has been registered.
// results sit in an output register; a stall on out_ready holds the emit walk.
// reset clears control state and loads the register defaults; memories are
// not cleared since every entry is written before it is read.
// registers: match_tolerance at 0x0, iteration_limit at 0x8 (64-bit data).
module logistic_map_cycle_finder
    import lmcf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_EMITTED   = MAX_EMITTED_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W+2:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [TOL_W-1:0] tol_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [ADDR_W-1:0] idx;

    assign idx    = paddr[ADDR_W+2:3];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            lim_reg <= LIM_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (idx == REG_TOL)
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
            else if (idx == REG_LIM)
            begin
                lim_reg <= pwdata[LIM_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx == REG_TOL)
        begin
            prdata = {{(64-TOL_W){1'b0}}, tol_reg};
        end
        else if (idx == REG_LIM)
        begin
            prdata = {{(64-LIM_W){1'b0}}, lim_reg};
        end
    end

    lmcf_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_EMITTED   (MAX_EMITTED)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .tol       (tol_reg),
        .lim       (lim_reg)
    );

endmodule
